// ----- hw/rtl/bstk_pkg.sv -----
// Shared types, constants and helper functions of the bounded sorted top-k list.
package bstk_pkg;

	// Sizing of the list and of the per-entry vector.
	localparam int CAPACITY   = 64;
	localparam int MAX_PARAMS = 16;

	// Field widths of the stream items.
	localparam int KEY_W      = 64;
	localparam int VAL_W      = 64;
	localparam int EIDX_W     = 4;
	localparam int RANK_IN_W  = 6;
	localparam int POS_W      = 7;
	localparam int COUNT_W    = 7;
	localparam int S_TDATA_W  = 144;
	localparam int M_TDATA_W  = 144;

	// Bit positions inside the input tdata.
	localparam int S_KEY_LSB  = 0;
	localparam int S_EIDX_LSB = S_KEY_LSB + KEY_W;
	localparam int S_VAL_LSB  = S_EIDX_LSB + EIDX_W;
	localparam int S_RANK_LSB = S_VAL_LSB + VAL_W;
	localparam int S_USED_W   = S_RANK_LSB + RANK_IN_W;

	// Bit positions inside the output tdata.
	localparam int M_POS_LSB  = 0;
	localparam int M_KEY_LSB  = M_POS_LSB + POS_W;
	localparam int M_VAL_LSB  = M_KEY_LSB + KEY_W;
	localparam int M_CNT_LSB  = M_VAL_LSB + VAL_W;
	localparam int M_USED_W   = M_CNT_LSB + COUNT_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 7;
	localparam int CAP_REG_W  = 7;
	localparam int NP_REG_W   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PARAM_COUNT = CFG_IDX_W'(1);

	localparam logic [CAP_REG_W-1:0] CAP_RESET = CAP_REG_W'(64);
	localparam logic [NP_REG_W-1:0]  NP_RESET  = NP_REG_W'(16);

	// Derived internal widths.
	localparam int RANK_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int PIDX_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int NP_W    = $clog2(MAX_PARAMS + 1);
	localparam int VS_DEPTH = CAPACITY * MAX_PARAMS;
	localparam int VS_AW   = $clog2(VS_DEPTH);

	// Insert position reported for a rejected insert (-1).
	localparam logic [POS_W-1:0] POS_REJECT = '1;

	typedef enum logic {
		OPC_INSERT = 1'b0,
		OPC_READ   = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_END,
		ST_SCAN,
		ST_COMMIT,
		ST_COPY,
		ST_RD_ENT,
		ST_RD_VEC,
		ST_RESULT
	} state_t;

	// One word of the rank-ordered entry memory.
	typedef struct packed {
		logic [RANK_W-1:0] slot;
		logic [KEY_W-1:0]  key;
	} entry_t;

	// Effective capacity, saturated into 1..CAPACITY.
	function automatic logic [CNT_W-1:0] cap_sat(input logic [CAP_REG_W-1:0] raw);
		int v;
		v = int'(raw);
		if (v < 1) begin
			v = 1;
		end else if (v > CAPACITY) begin
			v = CAPACITY;
		end
		return CNT_W'(v);
	endfunction

	// Effective vector length, saturated into 1..MAX_PARAMS.
	function automatic logic [NP_W-1:0] np_sat(input logic [NP_REG_W-1:0] raw);
		int v;
		v = int'(raw);
		if (v < 1) begin
			v = 1;
		end else if (v > MAX_PARAMS) begin
			v = MAX_PARAMS;
		end
		return NP_W'(v);
	endfunction

endpackage

// ----- hw/rtl/bounded_sorted_top_k_list.sv -----
// Bounded top-k list in descending key order, held in block memories.
// An insert item without the last mark is only staged. A read gives its result after the entry
// memory read and, for an element index below the param count, the vector memory read. A
// rejected insert gives its result without any shift or copy. A committed one gives it after the
// one-rank-a-cycle shift of the entry memory and the one-element-a-cycle copy into the vector
// memory. One item is in work at a time. Reset empties the list, restores capacity 64, 16 params.
module bounded_sorted_top_k_list (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata: fitness_key[63:0], elem_index[67:64], elem_value[131:68], rank[137:132]
	input  logic [bstk_pkg::S_TDATA_W-1:0]   s_tdata,
	// s_tuser: opcode
	input  logic                             s_tuser,
	input  logic                             s_tlast,
	// Result stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata: insert_position[6:0], read_key[70:7], read_value[134:71],
	//          entry_count[141:135]
	output logic [bstk_pkg::M_TDATA_W-1:0]   m_tdata,
	// m_tuser: read_valid
	output logic                             m_tuser,
	// Configuration writes.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bstk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bstk_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bstk_pkg::*;

	localparam logic [VS_AW-1:0] VS_STRIDE = VS_AW'(MAX_PARAMS);

	// Memories.
	entry_t           ent_mem [CAPACITY];
	logic [VAL_W-1:0] stg_mem [MAX_PARAMS];
	logic [VAL_W-1:0] vs_mem  [VS_DEPTH];

	// Control state.
	state_t               state_q, state_d;
	logic [CNT_W-1:0]     et_q;
	logic [CNT_W-1:0]     hw_q;
	logic [CAP_REG_W-1:0] cap_q;
	logic [NP_REG_W-1:0]  np_reg_q;
	logic                 m_tvalid_q;
	logic                 cp_vld_s1;

	// Working registers.
	logic signed [KEY_W-1:0] key_q;
	logic [RANK_W-1:0]       end_q, i_q, pos_q, slot_q;
	logic                    full_q;
	logic [EIDX_W-1:0]       eidx_q;
	logic [NP_W-1:0]         e_q, np_q;
	logic [VS_AW-1:0]        vs_wa_s1;
	logic [POS_W-1:0]        res_pos_q;
	logic [KEY_W-1:0]        res_key_q;
	logic [VAL_W-1:0]        res_val_q;
	logic                    res_rv_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic                    m_tuser_q;

	// Memory read data registers.
	entry_t           ent_rdata_q;
	logic [VAL_W-1:0] stg_rdata_q;
	logic [VAL_W-1:0] vs_rdata_q;

	// Memory controls.
	logic              ent_re, ent_we;
	logic [RANK_W-1:0] ent_ra, ent_wa;
	entry_t            ent_wd;
	logic              vs_re;
	logic [VS_AW-1:0]  vs_ra;
	logic              cp_issue;
	logic              out_load;

	// Input fields.
	logic signed [KEY_W-1:0] in_key;
	logic [EIDX_W-1:0]       in_eidx;
	logic [VAL_W-1:0]        in_val;
	logic [RANK_IN_W-1:0]    in_rank;
	opcode_t                 in_opc;
	logic                    in_xfer;

	// Derived conditions.
	logic [CNT_W-1:0]  cap_eff;
	logic [NP_W-1:0]   np_eff;
	logic              full_c;
	logic [RANK_W-1:0] end_c;
	logic              rank_ok;
	logic              key_gt;
	logic              out_free;
	logic [RANK_W-1:0] slot_c;

	function automatic logic [VS_AW-1:0] vs_addr(input logic [RANK_W-1:0] s,
		input logic [NP_W-1:0] e);
		return VS_AW'(VS_AW'(s) * VS_STRIDE + VS_AW'(e));
	endfunction

	// Unpack the input item.
	assign in_key  = s_tdata[S_KEY_LSB +: KEY_W];
	assign in_eidx = s_tdata[S_EIDX_LSB +: EIDX_W];
	assign in_val  = s_tdata[S_VAL_LSB +: VAL_W];
	assign in_rank = s_tdata[S_RANK_LSB +: RANK_IN_W];
	assign in_opc  = opcode_t'(s_tuser);
	assign in_xfer = s_tvalid && s_tready;

	// Effective settings and list conditions.
	assign cap_eff  = cap_sat(cap_q);
	assign np_eff   = np_sat(np_reg_q);
	assign full_c   = 32'(et_q) >= 32'(cap_eff);
	assign end_c    = full_c ? RANK_W'(et_q - CNT_W'(1)) : RANK_W'(et_q);
	assign rank_ok  = (32'(in_rank) < 32'(et_q)) && (32'(in_rank) < CAPACITY);
	assign key_gt   = key_q > $signed(ent_rdata_q.key);
	assign out_free = !m_tvalid_q || m_tready;
	// Ranks at or above the high-water mark were never written; their slot is taken to be the rank.
	assign slot_c   = (32'(end_q) >= 32'(hw_q)) ? end_q : ent_rdata_q.slot;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_opc == OPC_INSERT) begin
						state_d = s_tlast ? ST_INS_END : ST_IDLE;
					end else begin
						state_d = rank_ok ? ST_RD_ENT : ST_RESULT;
					end
				end
			end
			ST_INS_END: begin
				if (full_q && !key_gt) begin
					state_d = ST_RESULT;
				end else if (end_q == '0) begin
					state_d = ST_COMMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!key_gt || i_q == RANK_W'(1)) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: state_d = ST_COPY;
			ST_COPY: begin
				if (e_q == np_q) begin
					state_d = ST_RESULT;
				end
			end
			ST_RD_ENT: begin
				state_d = (32'(eidx_q) < 32'(np_eff)) ? ST_RD_VEC : ST_RESULT;
			end
			ST_RD_VEC: state_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory and handshake controls.
	always_comb begin
		s_tready = 1'b0;
		ent_re   = 1'b0;
		ent_ra   = '0;
		ent_we   = 1'b0;
		ent_wa   = '0;
		ent_wd   = ent_rdata_q;
		vs_re    = 1'b0;
		vs_ra    = '0;
		cp_issue = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && in_opc == OPC_INSERT && s_tlast) begin
					ent_re = 1'b1;
					ent_ra = end_c;
				end else if (s_tvalid && in_opc == OPC_READ && rank_ok) begin
					ent_re = 1'b1;
					ent_ra = RANK_W'(in_rank);
				end
			end
			ST_INS_END: begin
				if ((!full_q || key_gt) && end_q != '0) begin
					ent_re = 1'b1;
					ent_ra = RANK_W'(end_q - RANK_W'(1));
				end
			end
			ST_SCAN: begin
				// Shift the entry above down one rank and fetch the next one.
				if (key_gt) begin
					ent_we = 1'b1;
					ent_wa = i_q;
					ent_wd = ent_rdata_q;
					if (i_q != RANK_W'(1)) begin
						ent_re = 1'b1;
						ent_ra = RANK_W'(i_q - RANK_W'(2));
					end
				end
			end
			ST_COMMIT: begin
				ent_we      = 1'b1;
				ent_wa      = pos_q;
				ent_wd.slot = slot_q;
				ent_wd.key  = key_q;
			end
			ST_COPY: begin
				cp_issue = (e_q != np_q);
			end
			ST_RD_ENT: begin
				if (32'(eidx_q) < 32'(np_eff)) begin
					vs_re = 1'b1;
					vs_ra = vs_addr(ent_rdata_q.slot, NP_W'(eidx_q));
				end
			end
			ST_RD_VEC: begin
			end
			ST_RESULT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// Entry memory: one write and one read port.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		if (ent_re) begin
			ent_rdata_q <= ent_mem[ent_ra];
		end
	end

	// Staging buffer: written by insert items, read by the copy sweep.
	always_ff @(posedge clk) begin
		if (in_xfer && in_opc == OPC_INSERT && 32'(in_eidx) < MAX_PARAMS) begin
			stg_mem[PIDX_W'(in_eidx)] <= in_val;
		end
		if (cp_issue) begin
			stg_rdata_q <= stg_mem[PIDX_W'(e_q)];
		end
	end

	// Vector memory: written in the cycle after each staging read.
	always_ff @(posedge clk) begin
		if (cp_vld_s1) begin
			vs_mem[vs_wa_s1] <= stg_rdata_q;
		end
		if (vs_re) begin
			vs_rdata_q <= vs_mem[vs_ra];
		end
	end

	// Control registers, list count and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			et_q       <= '0;
			hw_q       <= '0;
			cap_q      <= CAP_RESET;
			np_reg_q   <= NP_RESET;
			m_tvalid_q <= 1'b0;
			cp_vld_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			cp_vld_s1 <= cp_issue;

			if (state_q == ST_COMMIT) begin
				if (!full_q) begin
					et_q <= et_q + CNT_W'(1);
				end
				if (32'(end_q) + 1 > 32'(hw_q)) begin
					hw_q <= CNT_W'(32'(end_q) + 1);
				end
			end

			if (cfg_valid) begin
				case (cfg_index)
					REG_CAPACITY: begin
						cap_q <= cfg_data[CAP_REG_W-1:0];
						// Drop entries past the new capacity.
						if (et_q > cap_sat(cfg_data[CAP_REG_W-1:0])) begin
							et_q <= cap_sat(cfg_data[CAP_REG_W-1:0]);
						end
					end
					REG_PARAM_COUNT: np_reg_q <= cfg_data[NP_REG_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Working registers of the insert and read sequences.
	always_ff @(posedge clk) begin
		if (cp_issue) begin
			vs_wa_s1 <= vs_addr(slot_q, e_q);
			e_q      <= e_q + NP_W'(1);
		end
		case (state_q)
			ST_IDLE: begin
				res_pos_q <= '0;
				res_key_q <= '0;
				res_val_q <= '0;
				res_rv_q  <= 1'b0;
				key_q     <= in_key;
				eidx_q    <= in_eidx;
				end_q     <= end_c;
				full_q    <= full_c;
			end
			ST_INS_END: begin
				slot_q <= slot_c;
				i_q    <= end_q;
				pos_q  <= '0;
				if (full_q && !key_gt) begin
					res_pos_q <= POS_REJECT;
				end
			end
			ST_SCAN: begin
				if (key_gt) begin
					i_q   <= RANK_W'(i_q - RANK_W'(1));
					pos_q <= '0;
				end else begin
					pos_q <= i_q;
				end
			end
			ST_COMMIT: begin
				res_pos_q <= POS_W'(pos_q);
				np_q      <= np_eff;
				e_q       <= '0;
			end
			ST_RD_ENT: begin
				res_key_q <= ent_rdata_q.key;
				res_rv_q  <= 1'b1;
			end
			ST_RD_VEC: begin
				res_val_q <= vs_rdata_q;
			end
			default: begin
			end
		endcase

		// Load the output register once the previous result is taken.
		if (out_load) begin
			m_tdata_q                         <= '0;
			m_tdata_q[M_POS_LSB +: POS_W]     <= res_pos_q;
			m_tdata_q[M_KEY_LSB +: KEY_W]     <= res_key_q;
			m_tdata_q[M_VAL_LSB +: VAL_W]     <= res_val_q;
			m_tdata_q[M_CNT_LSB +: COUNT_W]   <= COUNT_W'(et_q);
			m_tuser_q                         <= res_rv_q;
		end
	end

endmodule
